// File: src/cas_pkg.sv
// Shared action codes, status codes, field widths and result type of the compacting array store.
package cas_pkg;

   // Action codes of a request beat
   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_READ   = 3'd2;
   localparam logic [2:0] ACT_LAST   = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   // Status codes of a response beat
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Fixed field widths of the channels
   localparam int unsigned IDX_W  = 8;
   localparam int unsigned VAL_W  = 32;
   localparam int unsigned SIZE_W = 9;

   // One response beat
   typedef struct packed {
      logic [VAL_W-1:0]  read_value;
      logic [1:0]        status;
      logic [SIZE_W-1:0] count_after;
      logic [SIZE_W-1:0] capacity_after;
   } res_type;

endpackage

// File: src/cas_if.sv
// Request and response channel interfaces of the compacting array store.
interface cas_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  index;
   logic [31:0] value;

   modport source (output valid, output action, output index, output value, input ready);
   modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface cas_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_value;
   logic [1:0]  status;
   logic [8:0]  count_after;
   logic [8:0]  capacity_after;

   modport source (output valid, output read_value, output status, output count_after,
                   output capacity_after, input ready);
   modport sink   (input valid, input read_value, input status, input count_after,
                   input capacity_after, output ready);
endinterface

// File: src/compacting_array_store_unit.sv
// Top level of the compacting array store: sequencer plus element memory.
//
//   channel  dir  beat payload
//   req_ch   in   action, index, value
//   rsp_ch   out  read_value, status, count_after, capacity_after
//
// Append, clear and any failed action finish in the cycle that takes the request;
// read and read-last add one memory read. Delete moves the count - 1 - index
// tail entries down, one entry per cycle through the read port and the write port.
// Synchronous reset empties the store; memory contents are kept.
// A finished result waits in the response register while the next request is
// taken; a second finished result stalls the sequencer until the first leaves.
module compacting_array_store_unit #(
   parameter int unsigned DEPTH          = 256,
   parameter int unsigned DATA_WIDTH     = 32,
   parameter int unsigned START_CAPACITY = 4
) (
   input  logic      clock,
   input  logic      reset,
   cas_req_if.sink   req_ch,
   cas_rsp_if.source rsp_ch
);
   import cas_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // Sequencer
   cas_ctrl #(
      .DEPTH          (DEPTH),
      .DATA_WIDTH     (DATA_WIDTH),
      .START_CAPACITY (START_CAPACITY)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Element memory
   cas_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: src/cas_store.sv
// Element memory: one write port, one read port, registered read data.
module cas_store #(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned DATA_WIDTH = 32,
   localparam int unsigned AW        = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cas_ctrl.sv
// Sequencer: count and capacity, action decode, delete shift walk, response register.
module cas_ctrl #(
   parameter int unsigned DEPTH          = 256,
   parameter int unsigned DATA_WIDTH     = 32,
   parameter int unsigned START_CAPACITY = 4,
   localparam int unsigned AW            = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   cas_req_if.sink               req_ch,
   cas_rsp_if.source             rsp_ch,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [DATA_WIDTH-1:0] wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [DATA_WIDTH-1:0] rd_data
);
   import cas_pkg::*;

   // Size width covers DEPTH, the start capacity and the 9-bit port fields
   localparam int unsigned CW0 = $clog2(DEPTH + 1);
   localparam int unsigned CW1 = $clog2(START_CAPACITY + 1);
   localparam int unsigned CW2 = (CW0 > CW1) ? CW0 : CW1;
   localparam int unsigned CW  = (CW2 > SIZE_W) ? CW2 : SIZE_W;
   // Value bits that survive both the port and the store
   localparam int unsigned VW  = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] START_C = CW'(START_CAPACITY);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          rsp_valid_ff;
   res_type       rsp_ff;
   res_type       hold_ff;

   logic          out_free;
   logic          fin;
   res_type       res;
   logic [CW-1:0] idx_c;
   logic [CW-1:0] dec_cnt;
   logic [CW-1:0] shrunk_cap;
   logic [CW:0]   grown;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign idx_c    = CW'(req_ch.index);
   assign dec_cnt  = cnt_ff - CW'(1);
   assign grown    = {cap_ff, 1'b0};

   // Capacity after a delete that leaves dec_cnt elements
   always_comb begin
      shrunk_cap = cap_ff;
      if (dec_cnt != '0 && dec_cnt == (cap_ff >> 2) && (cap_ff >> 1) != '0) begin
         shrunk_cap = cap_ff >> 1;
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   // Action decode and shift walk
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cap_in   = cap_ff;
      ptr_in   = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = rd_data;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff + AW'(2);
      fin      = 1'b0;
      res      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.action)
                  ACT_APPEND: begin
                     fin = 1'b1;
                     if (cnt_ff >= DEPTH_C) begin
                        res.status = ST_FULL;
                     end else begin
                        if (cnt_ff >= cap_ff) begin
                           cap_in = (grown > (CW + 1)'(DEPTH)) ? DEPTH_C : grown[CW-1:0];
                        end
                        wr_en   = 1'b1;
                        wr_addr = AW'(cnt_ff);
                        wr_data = DATA_WIDTH'(req_ch.value[VW-1:0]);
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (idx_c >= cnt_ff) begin
                        fin        = 1'b1;
                        res.status = ST_RANGE;
                     end else if (idx_c == dec_cnt) begin
                        // last element: nothing to move
                        fin    = 1'b1;
                        cnt_in = dec_cnt;
                        cap_in = shrunk_cap;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_c + CW'(1));
                        ptr_in   = AW'(idx_c);
                        state_in = S_SHIFT;
                     end
                  end
                  ACT_READ: begin
                     if (idx_c >= cnt_ff) begin
                        fin        = 1'b1;
                        res.status = ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_c);
                        state_in = S_READ;
                     end
                  end
                  ACT_LAST: begin
                     if (cnt_ff == '0) begin
                        fin        = 1'b1;
                        res.status = ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(dec_cnt);
                        state_in = S_READ;
                     end
                  end
                  ACT_CLEAR: begin
                     fin    = 1'b1;
                     cnt_in = '0;
                     cap_in = START_C;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            fin            = 1'b1;
            res.read_value = VAL_W'(rd_data[VW-1:0]);
            state_in       = S_IDLE;
         end
         S_SHIFT: begin
            // move entry ptr+1 down to ptr; next read is two ahead of the write
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            if (CW'(ptr_ff) + CW'(2) == cnt_ff) begin
               fin      = 1'b1;
               cnt_in   = dec_cnt;
               cap_in   = shrunk_cap;
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(2);
               ptr_in  = ptr_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      res.count_after    = cnt_in[SIZE_W-1:0];
      res.capacity_after = cap_in[SIZE_W-1:0];
      // response register busy: park the result
      if (fin && !out_free) begin
         state_in = S_DONE;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= START_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cap_ff   <= cap_in;
         if ((fin || state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (fin && out_free) begin
         rsp_ff <= res;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_ff <= hold_ff;
      end
      if (fin && !out_free) begin
         hold_ff <= res;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.read_value     = rsp_ff.read_value;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.count_after    = rsp_ff.count_after;
   assign rsp_ch.capacity_after = rsp_ff.capacity_after;

endmodule
